/* rtl/dd_pkg.sv */
// Shared constants and types for the stream deduplicator.
`timescale 1ns / 1ps

package dd_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int VALUE_W = 32;
   localparam int SLOT_W = 6;
   localparam int SIZE_W = 7;

   // Control bits that travel with a word along the cell chain.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic found;   // matched or stored in some cell already
      logic is_new;  // stored by some cell
   } ctl_type;

endpackage

/* rtl/dd_ifs.sv */
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface dd_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [dd_pkg::VALUE_W-1:0] value;
   logic                              first;
   logic                              last;

   modport source (output valid, value, first, last, input ready);
   modport sink (input valid, value, first, last, output ready);
endinterface

interface dd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [dd_pkg::VALUE_W-1:0] value_out;
   logic                              is_new;
   logic [dd_pkg::SLOT_W-1:0]         slot;
   logic [dd_pkg::SIZE_W-1:0]         set_size;
   logic                              overflow;
   logic                              last_out;

   modport source (output valid, value_out, is_new, slot, set_size, overflow, last_out,
                   input ready);
   modport sink (input valid, value_out, is_new, slot, set_size, overflow, last_out,
                 output ready);
endinterface

/* rtl/dd_cell.sv */
// One table cell: holds one entry, compares and inserts as a word passes by.
`timescale 1ns / 1ps

module dd_cell #(
   parameter int IDX = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  dd_pkg::ctl_type                   in_ctl,
   input  logic signed [dd_pkg::VALUE_W-1:0] in_value,
   input  logic [IDX_W-1:0]                  in_slot,
   input  logic [CNT_W-1:0]                  in_count,
   output dd_pkg::ctl_type                   out_ctl,
   output logic signed [dd_pkg::VALUE_W-1:0] out_value,
   output logic [IDX_W-1:0]                  out_slot,
   output logic [CNT_W-1:0]                  out_count
);

   logic signed [dd_pkg::VALUE_W-1:0] entry_ff;
   logic                              occ_ff;
   logic                              occ_in;
   logic                              occ_eff;
   logic                              hit;
   logic                              take;
   dd_pkg::ctl_type                   ctl_ff;
   dd_pkg::ctl_type                   ctl_in;
   logic signed [dd_pkg::VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]                  slot_ff;
   logic [IDX_W-1:0]                  slot_in;
   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;

   // A word with first set empties every cell it passes, apart from the one it is stored in.
   assign occ_eff = occ_ff && !in_ctl.first;
   assign hit = in_ctl.valid && !in_ctl.found && occ_eff && (entry_ff == in_value);
   assign take = in_ctl.valid && !in_ctl.found && !occ_eff;

   always_comb begin
      occ_in = occ_ff;
      if (in_ctl.valid) begin
         occ_in = occ_eff || take;
      end
      ctl_in = in_ctl;
      ctl_in.found = in_ctl.found || hit || take;
      ctl_in.is_new = in_ctl.is_new || take;
      slot_in = (hit || take) ? IDX_W'(IDX) : in_slot;
      // occupied cells form a prefix, so the last one seen gives the count
      count_in = (in_ctl.valid && occ_in) ? CNT_W'(IDX + 1) : in_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         ctl_ff <= '0;
      end else if (adv) begin
         occ_ff <= occ_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (take) begin
            entry_ff <= in_value;
         end
         value_ff <= in_value;
         slot_ff <= slot_in;
         count_ff <= count_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_value = value_ff;
   assign out_slot = slot_ff;
   assign out_count = count_ff;

endmodule

/* rtl/stream_deduplicator.sv */
// Top level: order-preserving deduplicator built as a chain of table cells.
//
//   channel  dir  handshake            payload
//   req      in   req_port.valid/ready value, first, last
//   rsp      out  rsp_port.valid/ready value_out, is_new, slot, set_size, overflow, last_out
//
// One word enters per cycle and each word walks the chain one cell per cycle, unless a
// stalled response holds the chain. rsp valid rises once the word has been registered
// in every cell in turn; the last cell's registers are the output register.
// A word trails the one ahead by at least one cell and so sees its insert.
// Reset (synchronous) empties the table and drains the chain.
// A stalled response freezes the whole chain; req_port.ready drops with it.
`timescale 1ns / 1ps

module stream_deduplicator #(
   parameter int TABLE_DEPTH = dd_pkg::TABLE_DEPTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   dd_req_if.sink   req_port,
   dd_rsp_if.source rsp_port
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   dd_pkg::ctl_type                   ctl_s   [0:TABLE_DEPTH];
   logic signed [dd_pkg::VALUE_W-1:0] value_s [0:TABLE_DEPTH];
   logic [IDX_W-1:0]                  slot_s  [0:TABLE_DEPTH];
   logic [CNT_W-1:0]                  count_s [0:TABLE_DEPTH];
   logic                              adv;

   // last cell's registers serve as the output register
   assign adv = !ctl_s[TABLE_DEPTH].valid || rsp_port.ready;
   assign req_port.ready = adv;

   assign ctl_s[0] = '{valid: req_port.valid, first: req_port.first, last: req_port.last,
                       found: 1'b0, is_new: 1'b0};
   assign value_s[0] = req_port.value;
   assign slot_s[0] = '0;
   assign count_s[0] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      dd_cell #(
         .IDX(i),
         .IDX_W(IDX_W),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .adv(adv),
         .in_ctl(ctl_s[i]),
         .in_value(value_s[i]),
         .in_slot(slot_s[i]),
         .in_count(count_s[i]),
         .out_ctl(ctl_s[i+1]),
         .out_value(value_s[i+1]),
         .out_slot(slot_s[i+1]),
         .out_count(count_s[i+1])
      );
   end

   assign rsp_port.valid = ctl_s[TABLE_DEPTH].valid;
   assign rsp_port.value_out = value_s[TABLE_DEPTH];
   assign rsp_port.is_new = ctl_s[TABLE_DEPTH].is_new;
   // slot stays zero on overflow since no cell set it
   assign rsp_port.slot = dd_pkg::SLOT_W'(slot_s[TABLE_DEPTH]);
   assign rsp_port.set_size = dd_pkg::SIZE_W'(count_s[TABLE_DEPTH]);
   assign rsp_port.overflow = !ctl_s[TABLE_DEPTH].found;
   assign rsp_port.last_out = ctl_s[TABLE_DEPTH].last;

endmodule

/* rtl/dd_checker.sv */
// Port-level checks for the stream deduplicator, bound to the top level.
`timescale 1ns / 1ps

module dd_checker #(
   parameter int TABLE_DEPTH = dd_pkg::TABLE_DEPTH_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      is_new,
   input logic                      overflow,
   input logic [dd_pkg::SLOT_W-1:0] slot,
   input logic [dd_pkg::SIZE_W-1:0] set_size
);

   localparam logic SMALL = (TABLE_DEPTH <= 64);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_new_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(is_new && overflow))
      else $error("is_new and overflow both set");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> (set_size == dd_pkg::SIZE_W'(TABLE_DEPTH)) && (slot == '0))
      else $error("overflow without a full table");

   a_new_tail: assert property (@(posedge clock) disable iff (reset)
      SMALL && rsp_valid && is_new |->
         set_size == dd_pkg::SIZE_W'({1'b0, slot} + dd_pkg::SIZE_W'(1)))
      else $error("new entry not stored at the tail");

   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      SMALL && rsp_valid && !is_new && !overflow |-> {1'b0, slot} < set_size)
      else $error("matched slot beyond table size");

endmodule

bind stream_deduplicator dd_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_dd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_port.valid),
   .rsp_ready(rsp_port.ready),
   .is_new(rsp_port.is_new),
   .overflow(rsp_port.overflow),
   .slot(rsp_port.slot),
   .set_size(rsp_port.set_size)
);

/* dv/tb_top.sv */
// Self-checking testbench for the stream deduplicator: random lists, stalls on both channels.
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_DEPTH  = dd_pkg::TABLE_DEPTH_DEFAULT;
   localparam int RANDOM_WORDS = 2000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 32;

   typedef struct {
      logic signed [dd_pkg::VALUE_W-1:0] value;
      logic                              first;
      logic                              last;
   } list_word_type;

   typedef struct {
      logic signed [dd_pkg::VALUE_W-1:0] value_out;
      logic                              is_new;
      logic [dd_pkg::SLOT_W-1:0]         slot;
      logic [dd_pkg::SIZE_W-1:0]         set_size;
      logic                              overflow;
      logic                              last_out;
   } dedup_result_type;

   logic clock;
   logic reset;

   dd_req_if req ();
   dd_rsp_if rsp ();

   stream_deduplicator #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req),
      .rsp_port (rsp)
   );

   list_word_type    list_words[$];
   dedup_result_type dedup_expected[$];
   int               words_total;
   int               words_accepted;
   int               fail_count;

   // Shadow of the distinct-value table.
   logic signed [dd_pkg::VALUE_W-1:0] held_values[TABLE_DEPTH];
   int                                held_count;

   always #2 clock = ~clock;

   function automatic dedup_result_type predict_dedup(list_word_type w);
      dedup_result_type r;
      bit               hit;
      hit = 1'b0;
      if (w.first)
         held_count = 0;
      r.value_out = w.value;
      r.is_new    = 1'b0;
      r.slot      = '0;
      r.overflow  = 1'b0;
      r.last_out  = w.last;
      for (int i = 0; i < held_count; i++) begin
         if (!hit && held_values[i] == w.value) begin
            hit    = 1'b1;
            r.slot = dd_pkg::SLOT_W'(i);
         end
      end
      if (!hit) begin
         if (held_count < TABLE_DEPTH) begin
            held_values[held_count] = w.value;
            r.slot   = dd_pkg::SLOT_W'(held_count);
            held_count++;
            r.is_new = 1'b1;
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.set_size = dd_pkg::SIZE_W'(held_count);
      return r;
   endfunction

   // Idle percentages: sender/receiver swap roles per third of the run, then both run free.
   function automatic int send_idle_pct(int accepted);
      if (accepted < words_total / 3)
         return 9;
      else if (accepted < 2 * words_total / 3)
         return 79;
      return 0;
   endfunction

   function automatic int recv_idle_pct(int accepted);
      if (accepted < words_total / 3)
         return 79;
      else if (accepted < 2 * words_total / 3)
         return 9;
      return 0;
   endfunction

   // driver
   always @(posedge clock) begin
      list_word_type w;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid) begin
            w.value = req.value;
            w.first = req.first;
            w.last  = req.last;
            dedup_expected.push_back(predict_dedup(w));
            words_accepted <= words_accepted + 1;
         end
         if (list_words.size() > 0 && $urandom_range(99) >= send_idle_pct(words_accepted)) begin
            w = list_words.pop_front();
            req.valid <= 1'b1;
            req.value <= w.value;
            req.first <= w.first;
            req.last  <= w.last;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   task automatic compare_field(string field, longint want, longint got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      dedup_result_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (dedup_expected.size() == 0) begin
               $display("%0t unexpected response word: value_out %0d", $time, rsp.value_out);
               fail_count++;
            end else begin
               e = dedup_expected.pop_front();
               compare_field("value_out", e.value_out, rsp.value_out);
               compare_field("is_new", e.is_new, rsp.is_new);
               compare_field("slot", e.slot, rsp.slot);
               compare_field("set_size", e.set_size, rsp.set_size);
               compare_field("overflow", e.overflow, rsp.overflow);
               compare_field("last_out", e.last_out, rsp.last_out);
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct(words_accepted));
      end
   end

   task automatic add_word(logic signed [dd_pkg::VALUE_W-1:0] value, logic first, logic last);
      list_word_type w;
      w.value = value;
      w.first = first;
      w.last  = last;
      list_words.push_back(w);
   endtask

   function automatic logic signed [dd_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return $signed(dd_pkg::VALUE_W'($urandom_range(16))) - 8;
         1: return 32'sh8000_0000;
         2: return 32'sh7fff_ffff;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_lists();
      logic signed [dd_pkg::VALUE_W-1:0] pool[$];
      int kind, pool_len, len, n;
      while (list_words.size() < words_total) begin
         kind = $urandom_range(99);
         pool.delete();
         pool_len = (kind < 10) ? $urandom_range(76, 62) : $urandom_range(16, 1);
         for (int i = 0; i < pool_len; i++) begin
            // near-duplicates stress the comparators one bit at a time
            if (i > 0 && $urandom_range(3) == 0)
               pool.push_back(pool[$urandom_range(i - 1)] ^ (32'sh1 << $urandom_range(31)));
            else
               pool.push_back(pick_value());
         end
         if (kind < 10) begin
            // long list: walk the whole pool, then revisit and add strays, which can run past a full table
            len = pool_len + $urandom_range(20, 3);
            for (int i = 0; i < len; i++) begin
               if (i < pool_len)
                  add_word(pool[i], i == 0, 1'b0);
               else if ($urandom_range(2) == 0)
                  add_word(pick_value(), 1'b0, i == len - 1);
               else
                  add_word(pool[$urandom_range(pool_len - 1)], 1'b0, i == len - 1);
            end
         end else if (kind < 85) begin
            // well-formed list; some continue the previous table without first
            len = $urandom_range(24, 1);
            n = (kind < 72) ? 1 : 0;
            for (int i = 0; i < len; i++)
               add_word(pool[$urandom_range(pool_len - 1)], n == 1 && i == 0, i == len - 1);
         end else begin
            len = $urandom_range(10, 1);
            for (int i = 0; i < len; i++)
               add_word($urandom, $urandom_range(3) == 0, $urandom_range(3) == 0);
         end
      end
   endtask

   initial begin
      int drain;
      clock          = 1'b0;
      reset          = 1'b1;
      req.valid      = 1'b0;
      req.value      = '0;
      req.first      = 1'b0;
      req.last       = 1'b0;
      rsp.ready      = 1'b0;
      words_accepted = 0;
      fail_count     = 0;
      held_count     = 0;

      // directed: empty table after reset without first, extremes, repeats,
      // last with no following first, single-word list
      add_word(42, 1'b0, 1'b0);
      add_word(0, 1'b1, 1'b0);
      add_word(32'sh8000_0000, 1'b0, 1'b0);
      add_word(32'sh7fff_ffff, 1'b0, 1'b0);
      add_word(-1, 1'b0, 1'b0);
      add_word(0, 1'b0, 1'b0);
      add_word(32'sh8000_0000, 1'b0, 1'b0);
      add_word(1, 1'b0, 1'b0);
      add_word(-1, 1'b0, 1'b1);
      add_word(5, 1'b0, 1'b0);
      add_word(32'sh7fff_ffff, 1'b0, 1'b1);
      add_word(7, 1'b1, 1'b1);
      add_word(7, 1'b1, 1'b0);
      add_word(7, 1'b0, 1'b0);
      add_word(32'sh7fff_fffe, 1'b0, 1'b0);
      add_word(7, 1'b0, 1'b1);
      add_word(32'sh5555_5555, 1'b1, 1'b0);
      add_word(32'shaaaa_aaaa, 1'b0, 1'b1);

      words_total = list_words.size() + RANDOM_WORDS;
      add_random_lists();
      words_total = list_words.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted < words_total)
         @(posedge clock);
      while (dedup_expected.size() != 0)
         @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++)
         @(posedge clock);

      if (dedup_expected.size() != 0)
         $display("%0t %0d expected responses never arrived", $time, dedup_expected.size());
      if (fail_count == 0 && dedup_expected.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t timeout: %0d of %0d words accepted", $time, words_accepted, words_total);
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/dd_pkg.sv
rtl/dd_ifs.sv
rtl/dd_cell.sv
rtl/stream_deduplicator.sv
rtl/dd_checker.sv
dv/tb_top.sv
